// ----- design/ddcvcp_pkg.sv -----
// shared types and constants for the get-vcp reply checker
package ddcvcp_pkg;

  localparam int MAX_REPLY_BYTES = 16;
  localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);

  localparam logic [7:0] SRC_ADDR = 8'h6e;
  localparam logic [7:0] HOST_ADDR = 8'h50;
  localparam logic [7:0] GET_REPLY_OP = 8'h02;
  localparam int MARK_BIT_POS = 7;
  localparam int LEN_W = 7;
  localparam logic [LEN_W-1:0] VCP_PAYLOAD_LEN = LEN_W'(8);
  localparam int LEN_OVERHEAD = 3;
  localparam int MIN_REPLY_BYTES = 3;

  // byte positions inside the reply
  localparam int POS_SRC = 0;
  localparam int POS_LEN = 1;
  localparam int POS_OP = 2;
  localparam int POS_RESULT = 3;
  localparam int POS_CODE = 4;
  localparam int POS_TYPE = 5;
  localparam int POS_MAX_HI = 6;
  localparam int POS_MAX_LO = 7;
  localparam int POS_CUR_HI = 8;
  localparam int POS_CUR_LO = 9;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_NO_REPLY    = 2'd2,
    ST_MALFORMED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic [7:0] expected_code;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    status_t     status;
    logic        value_type;
    logic [15:0] maximum_value;
    logic [15:0] current_value;
  } reply_item_t;

endpackage

// ----- design/ddcvcp_in_reg.sv -----
// input register stage for received bytes
module ddcvcp_in_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic                   load_stall,
  input  ddcvcp_pkg::byte_item_t byte_data,
  output logic                   held_valid,
  output ddcvcp_pkg::byte_item_t held_item
);
  import ddcvcp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!load_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !load_stall) begin
      held_item <= byte_data;
    end
  end

endmodule

// ----- design/ddcvcp_parser.sv -----
// reply state, checksum and status evaluation for one byte per cycle while step is high
module ddcvcp_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  ddcvcp_pkg::byte_item_t  item,
  input  logic [7:0]              seed,
  output ddcvcp_pkg::reply_item_t result
);
  import ddcvcp_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [LEN_W-1:0] payload_length, payload_length_next;
  logic             header_bad, header_bad_next;
  logic             field_bad, field_bad_next;
  logic [7:0]       target_code, target_code_next;
  logic             result_one, result_one_next;
  logic             type_bit, type_bit_next;
  logic [15:0]      max_val, max_val_next;
  logic [15:0]      cur_val, cur_val_next;

  logic [7:0]       b;
  logic [7:0]       span_end;
  status_t          st;

  assign b = item.reply_byte;
  assign span_end = {1'b0, payload_length} + 8'(LEN_OVERHEAD);

  always_comb begin
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    payload_length_next = payload_length;
    header_bad_next     = header_bad;
    field_bad_next      = field_bad;
    target_code_next    = target_code;
    result_one_next     = result_one;
    type_bit_next       = type_bit;
    max_val_next        = max_val;
    cur_val_next        = cur_val;

    // a saturated count ignores the byte
    if (byte_count < CNT_W'(MAX_REPLY_BYTES)) begin
      byte_count_next = byte_count + CNT_W'(1);
      if (byte_count == CNT_W'(POS_SRC)) begin
        running_xor_next    = seed ^ b;
        payload_length_next = '0;
        header_bad_next     = (b != SRC_ADDR);
        field_bad_next      = 1'b0;
        target_code_next    = item.expected_code;
        result_one_next     = 1'b0;
        type_bit_next       = 1'b0;
        max_val_next        = '0;
        cur_val_next        = '0;
      end else if (byte_count == CNT_W'(POS_LEN)) begin
        running_xor_next    = running_xor ^ b;
        payload_length_next = b[LEN_W-1:0];
        if (!b[MARK_BIT_POS]) begin
          header_bad_next = 1'b1;
        end
      end else begin
        if ({{(8-CNT_W){1'b0}}, byte_count} < span_end) begin
          running_xor_next = running_xor ^ b;
        end
        case (byte_count)
          CNT_W'(POS_OP): begin
            if (b != GET_REPLY_OP) field_bad_next = 1'b1;
          end
          CNT_W'(POS_RESULT): begin
            result_one_next = (b == 8'd1);
            if (b > 8'd1) field_bad_next = 1'b1;
          end
          CNT_W'(POS_CODE): begin
            if (b != target_code) field_bad_next = 1'b1;
          end
          CNT_W'(POS_TYPE): begin
            type_bit_next = b[0];
            if (b > 8'd1) field_bad_next = 1'b1;
          end
          CNT_W'(POS_MAX_HI): max_val_next[15:8] = b;
          CNT_W'(POS_MAX_LO): max_val_next[7:0]  = b;
          CNT_W'(POS_CUR_HI): cur_val_next[15:8] = b;
          CNT_W'(POS_CUR_LO): cur_val_next[7:0]  = b;
          default: ;
        endcase
      end
    end
  end

  // status from the state as it stands after this byte
  always_comb begin
    if (byte_count_next < CNT_W'(MIN_REPLY_BYTES) || header_bad_next) begin
      st = ST_MALFORMED;
    end else if (({1'b0, payload_length_next} + 8'(LEN_OVERHEAD)) >
                 {{(8-CNT_W){1'b0}}, byte_count_next} || running_xor_next != 8'd0) begin
      st = ST_MALFORMED;
    end else if (payload_length_next == '0) begin
      st = ST_NO_REPLY;
    end else if (payload_length_next != VCP_PAYLOAD_LEN || field_bad_next) begin
      st = ST_MALFORMED;
    end else if (result_one_next) begin
      st = ST_UNSUPPORTED;
    end else begin
      st = ST_OK;
    end
    result.status = st;
    if (st == ST_OK) begin
      result.value_type    = type_bit_next;
      result.maximum_value = max_val_next;
      result.current_value = cur_val_next;
    end else begin
      result.value_type    = 1'b0;
      result.maximum_value = '0;
      result.current_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_xor    <= '0;
      payload_length <= '0;
      header_bad     <= 1'b0;
      field_bad      <= 1'b0;
      target_code    <= '0;
      result_one     <= 1'b0;
      type_bit       <= 1'b0;
      max_val        <= '0;
      cur_val        <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        // reply ends: start afresh
        byte_count     <= '0;
        running_xor    <= '0;
        payload_length <= '0;
        header_bad     <= 1'b0;
        field_bad      <= 1'b0;
        target_code    <= '0;
        result_one     <= 1'b0;
        type_bit       <= 1'b0;
        max_val        <= '0;
        cur_val        <= '0;
      end else begin
        byte_count     <= byte_count_next;
        running_xor    <= running_xor_next;
        payload_length <= payload_length_next;
        header_bad     <= header_bad_next;
        field_bad      <= field_bad_next;
        target_code    <= target_code_next;
        result_one     <= result_one_next;
        type_bit       <= type_bit_next;
        max_val        <= max_val_next;
        cur_val        <= cur_val_next;
      end
    end
  end

endmodule

// ----- design/ddcvcp_out_reg.sv -----
// result register holding one finished reply status
module ddcvcp_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  ddcvcp_pkg::reply_item_t result,
  input  logic                    reply_stall,
  output logic                    reply_valid,
  output ddcvcp_pkg::reply_item_t reply_data
);
  import ddcvcp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else if (load) begin
      reply_valid <= 1'b1;
    end else if (!reply_stall) begin
      reply_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reply_data <= result;
    end
  end

endmodule

// ----- design/ddc_vcp_reply_checker_unit.sv -----
// top level of the get-vcp reply checker
//
//   channel   direction  handshake                  payload
//   byte      in         byte_valid / byte_stall    byte_data (byte_item_t)
//   reply     out        reply_valid / reply_stall  reply_data (reply_item_t)
//   cfg       in         cfg_write_en               cfg_write_data (checksum seed)
//
// one byte per cycle unless byte_stall is high; a byte is registered, then parsed from the input register
// a last byte loads its status into the result register when it is parsed, other bytes give none
// synchronous reset clears the reply state and loads the seed with the host address
// byte_stall rises only while a last byte waits behind a stalled, full result register
module ddc_vcp_reply_checker_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  ddcvcp_pkg::byte_item_t  byte_data,
  output logic                    reply_valid,
  input  logic                    reply_stall,
  output ddcvcp_pkg::reply_item_t reply_data,
  input  logic                    cfg_write_en,
  input  logic [7:0]              cfg_write_data
);
  import ddcvcp_pkg::*;

  logic        held_valid;
  byte_item_t  held_item;
  logic        step;
  reply_item_t result;
  logic [7:0]  checksum_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_seed <= HOST_ADDR;
    end else if (cfg_write_en) begin
      checksum_seed <= cfg_write_data;
    end
  end

  // a held byte moves on unless it ends a reply and the result slot is blocked
  assign step = held_valid && (!held_item.last_byte || !reply_valid || !reply_stall);
  assign byte_stall = held_valid && !step;

  ddcvcp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .load_stall (byte_stall),
    .byte_data  (byte_data),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ddcvcp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .seed   (checksum_seed),
    .result (result)
  );

  ddcvcp_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (step && held_item.last_byte),
    .result      (result),
    .reply_stall (reply_stall),
    .reply_valid (reply_valid),
    .reply_data  (reply_data)
  );

endmodule

// ----- design/ddcvcp_checker.sv -----
// port-level checks for the get-vcp reply checker
module ddcvcp_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    byte_stall,
  input logic                    reply_valid,
  input logic                    reply_stall,
  input ddcvcp_pkg::reply_item_t reply_data
);
  import ddcvcp_pkg::*;

  // a stalled result transaction holds
  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_stall |=> reply_valid && $stable(reply_data))
    else $error("reply changed while stalled");

  // value fields are zero unless the reply is ok
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_data.status != ST_OK |->
      !reply_data.value_type && reply_data.maximum_value == 16'd0 &&
      reply_data.current_value == 16'd0)
    else $error("value fields set on a reply that is not ok");

  // input back-pressure only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> reply_valid && reply_stall)
    else $error("byte stall without a blocked result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !reply_valid && !byte_stall)
    else $error("activity right after reset");

endmodule

bind ddc_vcp_reply_checker_unit ddcvcp_checker u_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench for the get-vcp reply checker: random and directed replies
module tb_top;
  import ddcvcp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT = 5000;

  typedef enum int {
    RK_GOOD, RK_NO_REPLY, RK_OTHER_LEN, RK_BAD_SRC, RK_NO_MARK, RK_BAD_SUM, RK_BAD_OP,
    RK_BAD_CODE, RK_BAD_RESULT, RK_BAD_TYPE, RK_TRUNCATED, RK_TRAILING, RK_NOISE
  } reply_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  byte_item_t  byte_data = '0;
  logic        reply_valid;
  logic        reply_stall = 1'b0;
  reply_item_t reply_data;
  logic        cfg_write_en = 1'b0;
  logic [7:0]  cfg_write_data = '0;

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 87;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int          err_count = 0;
  int unsigned bytes_offered = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  logic [7:0]  seed_setting = HOST_ADDR;
  logic [7:0]  reply_bytes [$];
  reply_item_t expected_replies [$];

  // parser state as seen from outside
  int             rx_count = 0;
  logic [7:0]     rx_xor = '0;
  logic [LEN_W-1:0] rx_len = '0;
  logic           rx_hdr_bad = 1'b0;
  logic           rx_fld_bad = 1'b0;
  logic [7:0]     rx_target = '0;
  logic [7:0]     rx_result = '0;
  logic [7:0]     cap_type = '0;
  logic [15:0]    cap_max = '0;
  logic [15:0]    cap_cur = '0;

  ddc_vcp_reply_checker_unit dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_data      (byte_data),
    .reply_valid    (reply_valid),
    .reply_stall    (reply_stall),
    .reply_data     (reply_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task clear_tracker();
    rx_count = 0;
    rx_xor = '0;
    rx_len = '0;
    rx_hdr_bad = 1'b0;
    rx_fld_bad = 1'b0;
    rx_target = '0;
    rx_result = '0;
    cap_type = '0;
    cap_max = '0;
    cap_cur = '0;
  endtask

  function status_t judge_reply();
    if (rx_count < MIN_REPLY_BYTES || rx_hdr_bad) return ST_MALFORMED;
    if (int'(rx_len) + LEN_OVERHEAD > rx_count || rx_xor != 8'h00) return ST_MALFORMED;
    if (rx_len == '0) return ST_NO_REPLY;
    if (rx_len != VCP_PAYLOAD_LEN || rx_fld_bad) return ST_MALFORMED;
    if (rx_result == 8'd1) return ST_UNSUPPORTED;
    return ST_OK;
  endfunction

  task track_byte(byte_item_t item);
    reply_item_t r;
    logic [7:0]  b;
    int          idx;
    b = item.reply_byte;
    idx = rx_count;
    // a saturated count drops the byte, but a last flag still closes the reply
    if (idx < MAX_REPLY_BYTES) begin
      if (idx == POS_SRC) begin
        clear_tracker();
        rx_xor = seed_setting ^ b;
        rx_hdr_bad = (b != SRC_ADDR);
        rx_target = item.expected_code;
      end else if (idx == POS_LEN) begin
        rx_xor = rx_xor ^ b;
        rx_len = b[LEN_W-1:0];
        if (!b[MARK_BIT_POS]) rx_hdr_bad = 1'b1;
      end else begin
        if (idx < int'(rx_len) + LEN_OVERHEAD) rx_xor = rx_xor ^ b;
        case (idx)
          POS_OP: if (b != GET_REPLY_OP) rx_fld_bad = 1'b1;
          POS_RESULT: begin
            rx_result = b;
            if (b > 8'd1) rx_fld_bad = 1'b1;
          end
          POS_CODE: if (b != rx_target) rx_fld_bad = 1'b1;
          POS_TYPE: begin
            cap_type = b;
            if (b > 8'd1) rx_fld_bad = 1'b1;
          end
          POS_MAX_HI: cap_max[15:8] = b;
          POS_MAX_LO: cap_max[7:0] = b;
          POS_CUR_HI: cap_cur[15:8] = b;
          POS_CUR_LO: cap_cur[7:0] = b;
          default: ;
        endcase
      end
      rx_count = idx + 1;
    end
    if (item.last_byte) begin
      r = '0;
      r.status = judge_reply();
      if (r.status == ST_OK) begin
        r.value_type = cap_type[0];
        r.maximum_value = cap_max;
        r.current_value = cap_cur;
      end
      expected_replies.push_back(r);
      clear_tracker();
    end
  endtask

  task check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) track_byte(byte_data);
  end

  always @(posedge clk) begin
    reply_item_t want;
    if (!rst && reply_valid && !reply_stall) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected reply transaction: status %0d", reply_data.status);
        err_count++;
      end else begin
        want = expected_replies.pop_front();
        status_seen[int'(want.status)]++;
        check_field("status", 16'(want.status), 16'(reply_data.status));
        check_field("value_type", 16'(want.value_type), 16'(reply_data.value_type));
        check_field("maximum_value", want.maximum_value, reply_data.maximum_value);
        check_field("current_value", want.current_value, reply_data.current_value);
      end
    end
  end

  // output stall: a long hold-off when asked, random otherwise
  always @(posedge clk) begin
    if (hold_left > 0) begin
      reply_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      reply_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (reply_valid && !reply_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no transaction for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task send_byte(byte_item_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    byte_data <= item;
    do @(posedge clk); while (byte_stall);
    bytes_offered++;
  endtask

  // the requested code rides on the first byte; elsewhere it should be ignored
  task send_frame(logic [7:0] code);
    byte_item_t item;
    for (int i = 0; i < reply_bytes.size(); i++) begin
      item.reply_byte = reply_bytes[i];
      item.expected_code = (i == 0) ? code : 8'($urandom);
      item.last_byte = (i == reply_bytes.size() - 1);
      send_byte(item);
    end
  endtask

  task drain_replies();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_seed(logic [7:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    seed_setting = value;
  endtask

  task frame_good(logic [7:0] code, logic [7:0] result, logic [7:0] typ,
                  logic [15:0] maxv, logic [15:0] curv);
    reply_bytes.delete();
    reply_bytes.push_back(SRC_ADDR);
    reply_bytes.push_back({1'b1, VCP_PAYLOAD_LEN});
    reply_bytes.push_back(GET_REPLY_OP);
    reply_bytes.push_back(result);
    reply_bytes.push_back(code);
    reply_bytes.push_back(typ);
    reply_bytes.push_back(maxv[15:8]);
    reply_bytes.push_back(maxv[7:0]);
    reply_bytes.push_back(curv[15:8]);
    reply_bytes.push_back(curv[7:0]);
  endtask

  task frame_no_reply();
    reply_bytes.delete();
    reply_bytes.push_back(SRC_ADDR);
    reply_bytes.push_back({1'b1, 7'd0});
  endtask

  task append_checksum();
    logic [7:0] sum;
    sum = seed_setting;
    foreach (reply_bytes[i]) sum = sum ^ reply_bytes[i];
    reply_bytes.push_back(sum);
  endtask

  function logic [15:0] value16();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function logic [7:0] byte_other_than(logic [7:0] b);
    return b ^ 8'($urandom_range(1, 255));
  endfunction

  function reply_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return RK_GOOD;
    if (r < 55) return RK_NO_REPLY;
    if (r < 60) return RK_OTHER_LEN;
    return reply_kind_t'(int'(RK_BAD_SRC) + int'((r - 60) / 4));
  endfunction

  task send_random_reply(reply_kind_t kind);
    logic [7:0]  code;
    int unsigned len;
    int unsigned cut;
    code = 8'($urandom);
    frame_good(code, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)), value16(), value16());
    case (kind)
      RK_GOOD: append_checksum();
      RK_NO_REPLY: begin
        frame_no_reply();
        append_checksum();
      end
      RK_OTHER_LEN: begin
        // lengths past 13 cannot fit before the count saturates
        len = $urandom_range(1, 20);
        if (len == VCP_PAYLOAD_LEN) len = len + 1;
        reply_bytes.delete();
        reply_bytes.push_back(SRC_ADDR);
        reply_bytes.push_back({1'b1, 7'(len)});
        repeat (len) reply_bytes.push_back(8'($urandom));
        append_checksum();
      end
      RK_BAD_SRC: begin
        reply_bytes[POS_SRC] = byte_other_than(SRC_ADDR);
        append_checksum();
      end
      RK_NO_MARK: begin
        reply_bytes[POS_LEN] = {1'b0, VCP_PAYLOAD_LEN};
        append_checksum();
      end
      RK_BAD_SUM: begin
        append_checksum();
        cut = reply_bytes.size() - 1;
        reply_bytes[cut] = reply_bytes[cut] ^ 8'(1 << $urandom_range(0, 7));
      end
      RK_BAD_OP: begin
        reply_bytes[POS_OP] = byte_other_than(GET_REPLY_OP);
        append_checksum();
      end
      RK_BAD_CODE: begin
        reply_bytes[POS_CODE] = byte_other_than(code);
        append_checksum();
      end
      RK_BAD_RESULT: begin
        reply_bytes[POS_RESULT] = 8'($urandom_range(2, 255));
        append_checksum();
      end
      RK_BAD_TYPE: begin
        reply_bytes[POS_TYPE] = 8'($urandom_range(2, 255));
        append_checksum();
      end
      RK_TRUNCATED: begin
        append_checksum();
        cut = $urandom_range(1, 10);
        while (reply_bytes.size() > cut) void'(reply_bytes.pop_back());
      end
      RK_TRAILING: begin
        append_checksum();
        repeat ($urandom_range(1, 25)) reply_bytes.push_back(8'($urandom));
      end
      default: begin
        reply_bytes.delete();
        repeat ($urandom_range(1, 20)) reply_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) reply_bytes[POS_SRC] = SRC_ADDR;
      end
    endcase
    send_frame(code);
  endtask

  // extremes of every value field, each status, and a lone last byte, under the reset seed
  task test_directed();
    frame_good(8'hff, 8'd0, 8'd1, 16'hffff, 16'h0000);
    append_checksum();
    send_frame(8'hff);
    frame_good(8'h00, 8'd1, 8'd0, 16'h0000, 16'hffff);
    append_checksum();
    send_frame(8'h00);
    frame_no_reply();
    append_checksum();
    send_frame(8'($urandom));
    reply_bytes.delete();
    reply_bytes.push_back(SRC_ADDR);
    send_frame(8'($urandom));
  endtask

  // valid replies padded well past the byte count limit
  task test_saturation();
    logic [7:0] code;
    repeat (3) begin
      code = 8'($urandom);
      frame_good(code, 8'd0, 8'($urandom_range(0, 1)), value16(), value16());
      append_checksum();
      repeat ($urandom_range(6, 20)) reply_bytes.push_back(8'($urandom));
      send_frame(code);
    end
  endtask

  task test_random_traffic(int unsigned s_idle, int unsigned r_idle, logic [7:0] seed,
                           int unsigned nbytes);
    int unsigned stop_at;
    drain_replies();
    write_seed(seed);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = bytes_offered + nbytes;
    while (bytes_offered < stop_at) send_random_reply(pick_kind());
  endtask

  // output held off while one-byte replies keep coming, so the input has to stall
  task test_backpressure();
    byte_item_t item;
    drain_replies();
    write_seed(HOST_ADDR);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 150;
    repeat (24) begin
      item.reply_byte = 8'($urandom);
      item.expected_code = 8'($urandom);
      item.last_byte = 1'b1;
      send_byte(item);
    end
    repeat (3) send_random_reply(RK_GOOD);
    drain_replies();
    repeat (3) send_random_reply(pick_kind());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random_traffic(19, 87, 8'hff, 480);
    test_random_traffic(87, 19, 8'h00, 480);
    test_random_traffic(0, 0, 8'($urandom), 480);
    test_backpressure();
    drain_replies();
    $display("sent %0d bytes; replies ok %0d, unsupported %0d, no reply %0d, malformed %0d",
             bytes_offered, status_seen[ST_OK], status_seen[ST_UNSUPPORTED],
             status_seen[ST_NO_REPLY], status_seen[ST_MALFORMED]);
    $display("seeds 0x50, 0x00, 0xff and random; corrupt, short and overlong replies");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ddcvcp_pkg.sv
design/ddcvcp_in_reg.sv
design/ddcvcp_parser.sv
design/ddcvcp_out_reg.sv
design/ddc_vcp_reply_checker_unit.sv
design/ddcvcp_checker.sv
tb/tb_top.sv
